[design/i420hm_pkg.sv]
// Shared constants, codes and types of the I420 horizontal mirror.
package i420hm_pkg;

  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxHeight = 4096;

  localparam int unsigned CfgW    = 13;
  localparam int unsigned CfgIdxW = 1;

  localparam int unsigned RstWidth  = 640;
  localparam int unsigned RstHeight = 480;

  // Column index into one bank, line lengths and pending counts, row counts.
  localparam int unsigned ColW  = $clog2(MaxWidth);
  localparam int unsigned SizeW = $clog2(MaxWidth + 1);
  localparam int unsigned HgtW  = $clog2(MaxHeight + 1);
  localparam int unsigned RowW  = $clog2(2 * MaxHeight);
  localparam int unsigned TotW  = $clog2(2 * MaxHeight + 1);

  // Queue between the front and the back.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QLvlW  = $clog2(QDepth + 1);

  typedef enum logic [0:0] {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    PLANE_Y = 2'd0,
    PLANE_U = 2'd1,
    PLANE_V = 2'd2
  } plane_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  // One or two mirrored bytes caused by one request; the marks apply to the
  // final byte of the pair.
  typedef struct packed {
    logic [7:0] data0;
    logic [7:0] data1;
    logic       two;
    plane_e     plane;
    logic       last;
    logic       frame_end;
  } pair_t;

endpackage

[design/i420hm_if.sv]
// Request and result channel interfaces of the I420 horizontal mirror.
interface i420hm_req_if;
  import i420hm_pkg::*;

  logic       valid;
  logic       ready;
  cmd_e       command;
  logic [7:0] pixel_in;

  modport source (output valid, command, pixel_in, input ready);
  modport sink (input valid, command, pixel_in, output ready);
endinterface

interface i420hm_res_if;
  import i420hm_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] pixel_out;
  plane_e     plane;
  logic       last_in_line;
  logic       last_in_frame;

  modport source (output valid, pixel_out, plane, last_in_line, last_in_frame, input ready);
  modport sink (input valid, pixel_out, plane, last_in_line, last_in_frame, output ready);
endinterface

[design/i420hm_front.sv]
// Front end: request intake, frame position tracking and the ping-pong line store.
module i420hm_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [i420hm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [i420hm_pkg::CfgW-1:0]    cfg_data_i,
  i420hm_req_if.sink                     req_i,
  input  logic [i420hm_pkg::QLvlW-1:0]   q_level_i,
  output logic                           push_valid_o,
  output i420hm_pkg::pair_t              push_o
);
  import i420hm_pkg::*;

  function automatic int unsigned clamp_size(logic [CfgW-1:0] v, int unsigned hi);
    int unsigned x;
    x = 32'(v);
    if (x < 2) return 2;
    if (x > hi) return hi;
    return x;
  endfunction

  // Sizes are kept already clamped, together with the plane boundaries.
  logic [SizeW-1:0]   w_q, w_d;
  logic [SizeW-2:0]   half_q, half_d;
  logic [HgtW-1:0]    h_q, h_d;
  logic [TotW-1:0]    hch_q, hch_d;
  logic [TotW-1:0]    tot_q, tot_d;
  logic [SizeW-1:0]   wc;
  logic [HgtW-1:0]    hc;

  logic [ColW-1:0]    col_q, col_d;
  logic [RowW-1:0]    row_q, row_d;
  logic               bank_q, bank_d;
  logic [SizeW-1:0]   pend_q, pend_d;
  plane_e             pend_plane_q, pend_plane_d;
  logic               pend_fend_q, pend_fend_d;

  logic               s2_valid_q;
  logic               s2_two_q;
  plane_e             s2_plane_q;
  logic               s2_last_q;
  logic               s2_fend_q;
  logic [7:0]         rdata0_q, rdata1_q;

  logic [7:0]         mem [2**(ColW+1)];

  logic               accept, is_pixel, has_pend, two, line_end, frame_last, last;
  plane_e             plane;
  logic [TotW-1:0]    row_ext;
  logic [SizeW-1:0]   len, col_ext, col_inc, remaining, pend_m1, pend_m2, pend_after;
  logic [ColW:0]      wr_addr, rd_addr0, rd_addr1;

  // Configuration decode.
  always_comb begin
    wc    = SizeW'(clamp_size(cfg_data_i, MaxWidth));
    hc    = HgtW'(clamp_size(cfg_data_i, MaxHeight));
    w_d   = w_q;
    half_d = half_q;
    h_d   = h_q;
    hch_d = hch_q;
    tot_d = tot_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_WIDTH: begin
          w_d    = wc;
          half_d = wc[SizeW-1:1];
        end
        CFG_FRAME_HEIGHT: begin
          h_d   = hc;
          hch_d = TotW'(hc) + TotW'(hc[HgtW-1:1]);
          tot_d = TotW'(hc) + TotW'({hc[HgtW-1:1], 1'b0});
        end
        default: ;
      endcase
    end
  end

  assign req_i.ready = ({1'b0, q_level_i} + (QLvlW+1)'(s2_valid_q)) < (QLvlW+1)'(QDepth);
  assign accept      = req_i.valid && req_i.ready;
  assign is_pixel    = (req_i.command == CMD_PIXEL);

  always_comb begin
    row_ext = TotW'(row_q);
    if (row_ext < TotW'(h_q)) begin
      plane = PLANE_Y;
    end else if (row_ext < hch_q) begin
      plane = PLANE_U;
    end else begin
      plane = PLANE_V;
    end
    len        = (plane == PLANE_Y) ? w_q : SizeW'(half_q);
    col_ext    = SizeW'(col_q);
    col_inc    = col_ext + SizeW'(1);
    remaining  = (len > col_ext) ? len - col_ext : SizeW'(1);
    has_pend   = (pend_q != '0);
    two        = is_pixel && (pend_q > remaining);
    line_end   = is_pixel && (col_inc >= len);
    frame_last = (row_ext + TotW'(1)) >= tot_q;
    pend_m1    = pend_q - SizeW'(1);
    pend_m2    = pend_q - SizeW'(2);
    pend_after = two ? pend_m2 : (has_pend ? pend_m1 : pend_q);
    last       = (pend_after == '0);
    wr_addr    = {bank_q, col_q};
    rd_addr0   = {~bank_q, pend_m1[ColW-1:0]};
    rd_addr1   = {~bank_q, pend_m2[ColW-1:0]};

    col_d        = col_q;
    row_d        = row_q;
    bank_d       = bank_q;
    pend_d       = pend_q;
    pend_plane_d = pend_plane_q;
    pend_fend_d  = pend_fend_q;
    if (accept) begin
      pend_d = pend_after;
      if (line_end) begin
        pend_d       = col_inc;
        pend_plane_d = plane;
        pend_fend_d  = frame_last;
        bank_d       = ~bank_q;
        col_d        = '0;
        row_d        = frame_last ? '0 : row_q + RowW'(1);
      end else if (is_pixel) begin
        col_d = col_inc[ColW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q          <= SizeW'(RstWidth);
      half_q       <= (SizeW-1)'(RstWidth / 2);
      h_q          <= HgtW'(RstHeight);
      hch_q        <= TotW'(RstHeight + RstHeight / 2);
      tot_q        <= TotW'(RstHeight + 2 * (RstHeight / 2));
      col_q        <= '0;
      row_q        <= '0;
      bank_q       <= 1'b0;
      pend_q       <= '0;
      pend_plane_q <= PLANE_Y;
      pend_fend_q  <= 1'b0;
      s2_valid_q   <= 1'b0;
    end else begin
      w_q          <= w_d;
      half_q       <= half_d;
      h_q          <= h_d;
      hch_q        <= hch_d;
      tot_q        <= tot_d;
      col_q        <= col_d;
      row_q        <= row_d;
      bank_q       <= bank_d;
      pend_q       <= pend_d;
      pend_plane_q <= pend_plane_d;
      pend_fend_q  <= pend_fend_d;
      s2_valid_q   <= accept && has_pend;
    end
  end

  // Line store: one write and two reads per cycle, read data registered.
  // Reads always target the other bank from the write.
  always_ff @(posedge clk_i) begin
    if (accept && is_pixel) begin
      mem[wr_addr] <= req_i.pixel_in;
    end
    if (accept) begin
      rdata0_q   <= mem[rd_addr0];
      rdata1_q   <= mem[rd_addr1];
      s2_two_q   <= two;
      s2_plane_q <= pend_plane_q;
      s2_last_q  <= last;
      s2_fend_q  <= last && pend_fend_q;
    end
  end

  assign push_valid_o = s2_valid_q;
  assign push_o = '{data0: rdata0_q, data1: rdata1_q, two: s2_two_q, plane: s2_plane_q,
                    last: s2_last_q, frame_end: s2_fend_q};

endmodule

[design/i420hm_queue.sv]
// Short queue of byte pairs between the front end and the output stage.
module i420hm_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_valid_i,
  input  i420hm_pkg::pair_t            push_i,
  input  logic                         pop_i,
  output logic                         head_valid_o,
  output i420hm_pkg::pair_t            head_o,
  output logic [i420hm_pkg::QLvlW-1:0] level_o
);
  import i420hm_pkg::*;

  pair_t             slots_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QLvlW-1:0]  level_q, level_d;
  logic              do_pop;

  assign do_pop = pop_i && (level_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (push_valid_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    if (push_valid_i && !do_pop) begin
      level_d = level_q + QLvlW'(1);
    end else if (!push_valid_i && do_pop) begin
      level_d = level_q - QLvlW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_valid_i) begin
      slots_q[wr_ptr_q] <= push_i;
    end
  end

  assign head_valid_o = (level_q != '0);
  assign head_o       = slots_q[rd_ptr_q];
  assign level_o      = level_q;

endmodule

[design/i420hm_back.sv]
// Output stage: unpacks byte pairs into single results behind an output register.
module i420hm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  i420hm_pkg::pair_t head_i,
  output logic              pop_o,
  i420hm_res_if.source      res_o
);
  import i420hm_pkg::*;

  pair_t cur_q;
  logic  cur_valid_q;
  logic  sel_q;
  logic  take, last_byte, load;

  assign take      = res_o.valid && res_o.ready;
  assign last_byte = !cur_q.two || sel_q;
  assign load      = head_valid_i && (!cur_valid_q || (take && last_byte));
  assign pop_o     = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else if (load) begin
      cur_valid_q <= 1'b1;
      sel_q       <= 1'b0;
    end else if (take) begin
      if (last_byte) begin
        cur_valid_q <= 1'b0;
      end else begin
        sel_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= head_i;
    end
  end

  assign res_o.valid         = cur_valid_q;
  assign res_o.pixel_out     = sel_q ? cur_q.data1 : cur_q.data0;
  assign res_o.plane         = cur_q.plane;
  assign res_o.last_in_line  = last_byte && cur_q.last;
  assign res_o.last_in_frame = last_byte && cur_q.frame_end;

endmodule

[design/i420_horizontal_mirror.sv]
// Top level of the I420 horizontal mirror: front end, pair queue and output stage.
//
// The block takes a planar I420 frame one byte per request in raster order (the Y lines,
// then the U lines, then the V lines, chroma at half width and half height, rounded down)
// and returns every line reversed left to right. Each incoming line is written into one
// bank of an 8192-byte ping-pong line store while the previous line is read out backwards
// from the other bank; the store needs no clearing pass after reset, as an entry is only
// read once it has been written. A pixel request releases one pending byte, or two when
// the previous line would otherwise not be finished by the end of the current one; a
// drain request releases one pending byte. Results carry the plane, an end-of-line mark
// and an end-of-frame mark. The front end accepts one request per clock for as long as
// the four-entry pair queue has room, and the output stage delivers one result per clock
// while the receiver is ready, so a frame streams at one byte per clock in and out; a
// result passes from the store's registered read data through the pair queue into the
// output register. The store's two read ports and one write port, used once per request,
// set that rate. The user must write frame size registers only while the block is idle;
// the block does not enforce this. Out-of-range sizes are clamped to between 2 and 4096.
module i420_horizontal_mirror (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [i420hm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [i420hm_pkg::CfgW-1:0]    cfg_data_i,
  i420hm_req_if.sink                     req_i,
  i420hm_res_if.source                   res_o
);
  import i420hm_pkg::*;

  // Pairs travel from the front end to the queue, and the queue's fill level
  // comes back so that the front end never overruns it.
  logic             push_valid;
  pair_t            push_pair;
  logic             pop;
  logic             head_valid;
  pair_t            head_pair;
  logic [QLvlW-1:0] q_level;

  i420hm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .req_i        (req_i),
    .q_level_i    (q_level),
    .push_valid_o (push_valid),
    .push_o       (push_pair)
  );

  i420hm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_i       (push_pair),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_pair),
    .level_o      (q_level)
  );

  // The output stage holds the current pair and hands out its bytes in order.
  i420hm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_pair),
    .pop_o        (pop),
    .res_o        (res_o)
  );

endmodule

[bench/testbench.sv]
// Self-checking testbench of the I420 horizontal mirror: line-reversal predictor, driver, monitor.
`timescale 1ns / 100ps

module testbench;
  import i420hm_pkg::*;

  // Idle cycles left for the block's three stages to empty before a size change and at the end.
  localparam int SettleCycles = 8;
  // Length of the deliberate receiver hold-off, long enough to fill the pair queue.
  localparam int LongHold = 300;
  // Cycles without any handshake after which the run is declared hung.
  localparam int QuietLimit = 2000;

  // One mirrored byte as the result channel delivers it.
  typedef struct packed {
    logic [7:0] pixel_out;
    plane_e     plane;
    logic       last_in_line;
    logic       last_in_frame;
  } mirrored_byte_t;

  // One request waiting to be offered to the block.
  typedef struct packed {
    cmd_e       command;
    logic [7:0] pixel_in;
  } frame_req_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  cfg_idx_e            cfg_idx;
  logic [CfgW-1:0]     cfg_data;

  i420hm_req_if req_ch ();
  i420hm_res_if res_ch ();

  i420_horizontal_mirror dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_ch),
    .res_o      (res_ch)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------------------
  // Line-reversal predictor. It keeps its own copy of the ping-pong store, the write
  // position, the row within the frame and the line that is waiting to be read out.
  // ---------------------------------------------------------------------------------------
  logic [7:0]       line_mem [2*MaxWidth];
  logic [ColW-1:0]  wr_col;
  logic [RowW-1:0]  row_idx;
  logic             wr_bank;
  logic [SizeW-1:0] held_count;
  plane_e           held_plane;
  logic             held_frame_end;
  logic [CfgW-1:0]  cfg_width;
  logic [CfgW-1:0]  cfg_height;

  // Mirrored bytes predicted but not yet delivered, oldest first.
  mirrored_byte_t   mirrored_due[$];
  // Requests that the sequencer has queued and the driver has not yet offered.
  frame_req_t       pending_reqs[$];

  int               faults = 0;
  int               feed_gap_pct = 33;
  int               take_gap_pct = 33;
  int               hold_requests = 0;
  int               hold_served = 0;
  int               hold_left = 0;
  int               quiet_cycles = 0;

  // Sizes outside the supported range are used clamped, so every line holds a byte.
  function automatic int unsigned clamp_size(logic [CfgW-1:0] value, int unsigned upper);
    if (value < 2) return 2;
    if (value > upper) return upper;
    return value;
  endfunction

  // Reads the next byte of the waiting line, walking its columns from last to first.
  function automatic void release_held_byte();
    mirrored_byte_t  b;
    logic [ColW-1:0] col;
    col = ColW'(held_count - 1'b1);
    b.pixel_out = line_mem[{~wr_bank, col}];
    held_count = held_count - 1'b1;
    b.plane = held_plane;
    b.last_in_line = (held_count == 0);
    b.last_in_frame = b.last_in_line && held_frame_end;
    mirrored_due.push_back(b);
  endfunction

  function automatic void predict_request(cmd_e cmd, logic [7:0] pix);
    int unsigned w;
    int unsigned h;
    int unsigned half_h;
    int unsigned rows;
    int unsigned len;
    int unsigned left;
    plane_e      pl;
    bit          frame_last;
    if (cmd == CMD_DRAIN) begin
      if (held_count != 0) release_held_byte();
      return;
    end
    w = clamp_size(cfg_width, MaxWidth);
    h = clamp_size(cfg_height, MaxHeight);
    half_h = h / 2;
    rows = h + 2 * half_h;
    // A row beyond the frame, left behind by a smaller height, is taken as the last V line.
    if (row_idx < h) pl = PLANE_Y;
    else if (row_idx < h + half_h) pl = PLANE_U;
    else pl = PLANE_V;
    len = (pl == PLANE_Y) ? w : w / 2;
    left = (len > wr_col) ? len - wr_col : 1;
    // A second byte goes out whenever the waiting line would outlast the current one.
    if (held_count != 0) begin
      release_held_byte();
      if (held_count + 1 > left && held_count != 0) release_held_byte();
    end
    line_mem[{wr_bank, wr_col}] = pix;
    if (wr_col + 1 >= len) begin
      // Whatever is still waiting from the previous line is lost when this one completes.
      frame_last = (row_idx + 1 >= rows);
      held_count = SizeW'(wr_col) + SizeW'(1);
      held_plane = pl;
      held_frame_end = frame_last;
      wr_bank = ~wr_bank;
      wr_col = '0;
      row_idx = frame_last ? '0 : row_idx + 1'b1;
    end else begin
      wr_col = wr_col + 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // Driver: offers the queued requests, keeping a request steady until it is taken, and
  // updates the predictor at the edge at which the block accepts one.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin : feed
    frame_req_t nxt;
    if (rst_n) begin
      if (req_ch.valid && req_ch.ready) predict_request(req_ch.command, req_ch.pixel_in);
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= feed_gap_pct) begin
          nxt = pending_reqs.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.command <= nxt.command;
          req_ch.pixel_in <= nxt.pixel_in;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor: compares every delivered byte with the oldest prediction and decides when the
  // result channel is ready. A hold-off asked for by the sequencer is counted out here.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin : take
    mirrored_byte_t want;
    if (rst_n) begin
      if (res_ch.valid && res_ch.ready) begin
        if (mirrored_due.size() == 0) begin
          $error("result with no byte outstanding: pixel_out %0d plane %0d",
                 res_ch.pixel_out, res_ch.plane);
          faults++;
        end else begin
          want = mirrored_due.pop_front();
          if (res_ch.pixel_out !== want.pixel_out) begin
            $error("pixel_out: expected %0d, got %0d", want.pixel_out, res_ch.pixel_out);
            faults++;
          end
          if (res_ch.plane !== want.plane) begin
            $error("plane: expected %0d, got %0d", want.plane, res_ch.plane);
            faults++;
          end
          if (res_ch.last_in_line !== want.last_in_line) begin
            $error("last_in_line: expected %0b, got %0b", want.last_in_line,
                   res_ch.last_in_line);
            faults++;
          end
          if (res_ch.last_in_frame !== want.last_in_frame) begin
            $error("last_in_frame: expected %0b, got %0b", want.last_in_frame,
                   res_ch.last_in_frame);
            faults++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        res_ch.ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = LongHold;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= take_gap_pct);
      end
    end
  end

  // Watchdog: a long stretch with no handshake on either side means the block has hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sequencer helpers.
  // ---------------------------------------------------------------------------------------
  task automatic queue_request(cmd_e cmd, logic [7:0] pix);
    frame_req_t r;
    r.command = cmd;
    r.pixel_in = pix;
    pending_reqs.push_back(r);
  endtask

  // Mostly pixel bytes, which always continue the frame, with the odd drain mixed in.
  task automatic queue_random(int count);
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) queue_request(CMD_DRAIN, 8'($urandom));
      else queue_request(CMD_PIXEL, 8'($urandom));
    end
  endtask

  // Waits until every request is taken and every predicted byte has come back, then lets
  // the pipeline settle, since a drain on an empty line gives nothing to wait for.
  task automatic wait_for_quiet();
    @(negedge clk);
    while (pending_reqs.size() != 0 || req_ch.valid || mirrored_due.size() != 0)
      @(negedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Both size registers are written back to back on the configuration port.
  task automatic set_frame_size(logic [CfgW-1:0] width, logic [CfgW-1:0] height);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_FRAME_WIDTH;
    cfg_data <= width;
    @(posedge clk);
    cfg_idx <= CFG_FRAME_HEIGHT;
    cfg_data <= height;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_width = width;
    cfg_height = height;
  endtask

  task automatic run_phase(logic [CfgW-1:0] width, logic [CfgW-1:0] height, int count,
                           int gap_pct, bit hold);
    wait_for_quiet();
    set_frame_size(width, height);
    @(negedge clk);
    feed_gap_pct = gap_pct;
    take_gap_pct = gap_pct;
    if (hold) hold_requests++;
    queue_random(count);
  endtask

  // ---------------------------------------------------------------------------------------
  // Sequencer: directed frames first, then random content under a series of frame sizes.
  // ---------------------------------------------------------------------------------------
  initial begin : sequencer
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_FRAME_WIDTH;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.command = CMD_PIXEL;
    req_ch.pixel_in = 8'h00;
    res_ch.ready = 1'b0;
    wr_col = '0;
    row_idx = '0;
    wr_bank = 1'b0;
    held_count = '0;
    held_plane = PLANE_Y;
    held_frame_end = 1'b0;
    cfg_width = CfgW'(RstWidth);
    cfg_height = CfgW'(RstHeight);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // A complete 4x2 frame: a drain with nothing waiting, two Y lines, one U and one V
    // line, and drains that flush the V line with its end-of-frame mark. The byte values
    // include 0 and 255 and set every bit both ways.
    set_frame_size(CfgW'(4), CfgW'(2));
    @(negedge clk);
    queue_request(CMD_DRAIN, 8'hFF);
    for (int i = 0; i < 12; i++) queue_request(CMD_PIXEL, 8'(i * 85));
    repeat (2) queue_request(CMD_DRAIN, 8'h00);

    // Odd width: the last Y line cannot be read out within the shorter U line, so one of
    // its bytes is lost when the U line completes.
    wait_for_quiet();
    set_frame_size(CfgW'(3), CfgW'(2));
    @(negedge clk);
    repeat (8) queue_request(CMD_PIXEL, 8'($urandom));
    queue_request(CMD_DRAIN, 8'h5A);

    // A wide line, starting at the head of a frame, read back in part while the next line
    // is written.
    run_phase(CfgW'(400), CfgW'(2), 440, 33, 1'b0);
    // Smallest frame, with the receiver held off so that the block fills and stalls.
    run_phase(CfgW'(2), CfgW'(2), 80, 33, 1'b1);
    // Sizes below the minimum are clamped.
    run_phase(CfgW'(0), CfgW'(1), 40, 33, 1'b0);
    // A stretch without idling on either side.
    run_phase(CfgW'($urandom_range(2, 16)), CfgW'($urandom_range(2, 8)), 100, 0, 1'b0);
    run_phase(CfgW'(7), CfgW'(3), 60, 33, 1'b0);
    // Tallest frame and a clamped height, only partly streamed.
    run_phase(CfgW'(2), CfgW'(4096), 60, 33, 1'b0);
    run_phase(CfgW'(3), CfgW'(8191), 40, 33, 1'b0);
    // Clamped width, then a shrink in mid-line and mid-frame: the open line ends at once
    // and rows past the new frame count as its last V line.
    run_phase(CfgW'(8191), CfgW'(2), 40, 33, 1'b0);
    run_phase(CfgW'(5), CfgW'(2), 50, 33, 1'b0);
    repeat (4) begin
      run_phase(CfgW'($urandom_range(2, 20)), CfgW'($urandom_range(2, 8)), 40, 33, 1'b0);
    end

    wait_for_quiet();
    if (faults == 0 && mirrored_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[i420_horizontal_mirror.f]
design/i420hm_pkg.sv
design/i420hm_if.sv
design/i420hm_front.sv
design/i420hm_queue.sv
design/i420hm_back.sv
design/i420_horizontal_mirror.sv
bench/testbench.sv
